// ----- rtl/core/wfa_pkg.sv -----
// ----------------------------------------------------------------------------
// wfa_pkg - shared constants and types for the windowed average
// Field widths, stream word layout and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package wfa_pkg;

    localparam int SAMPLE_W    = 16;   // sample, evicted value and mean
    localparam int COUNT_OUT_W = 3;    // held_count field
    localparam int STEP_W      = 4;    // divider step counter, SAMPLE_W steps
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;   // 35 field bits padded to bytes
    localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * SAMPLE_W - COUNT_OUT_W;

    typedef struct packed {
        logic                   ev_flag;
        logic [SAMPLE_W-1:0]    ev_value;
        logic [SAMPLE_W-1:0]    mean;
        logic [COUNT_OUT_W-1:0] count;
    } wfa_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/wfa_ram.sv -----
// ----------------------------------------------------------------------------
// wfa_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module wfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 5
) (
    input  wire logic                                  clk,
    input  wire logic                                  wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/windowed_fifo_average_top.sv -----
// ----------------------------------------------------------------------------
// windowed_fifo_average_top - moving average over the last WINDOW samples
// Sample store in RAM, running sum, bit-serial rounding divider.
// ----------------------------------------------------------------------------
// Usage
//   Input stream s_*: one 16-bit unsigned sample per word in s_tdata.
//   Output stream m_*: one word per sample. m_tuser is the evicted flag;
//   m_tdata carries evicted value, rounded mean and held count.
//   Each sample is appended to a window of at most WINDOW values; once the
//   window is full the oldest value is dropped and reported with the word.
//   The mean is (2*sum + count) / (2*count), i.e. round half up.
// Timing
//   A sample's oldest slot is read at the accepting edge; the sequencer then
//   updates the sum, sets up the divide, runs the restoring divider (one
//   quotient bit per cycle) and hands the result over to the output register.
//   s_tready is high only while the sequencer is idle, so a new sample is
//   taken only once the previous one has been handed over.
// Reset and stalls
//   rst_n clears the sequencer, count, oldest slot, sum and the output valid;
//   the RAM is not cleared, stale entries are never used. If m_tready is held
//   low the finished word waits in the output register and the next sample
//   is still taken and worked on; it then waits until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_fifo_average_top
    import wfa_pkg::*;
#(
    parameter int WINDOW = 5
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] sample_value
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // [15:0] evicted_value,
                                                   // [31:16] window_mean,
                                                   // [34:32] held_count, pad
    output logic                        m_tuser    // [0] evicted_valid
);

    localparam int CW  = $clog2(WINDOW + 1);               // fill count
    localparam int SLW = (WINDOW > 1) ? $clog2(WINDOW) : 1; // slot index
    localparam int AW  = CW + 1;                           // slot arithmetic
    localparam int SW  = SAMPLE_W + CW;                    // running sum
    localparam int NW  = SW + 1;                           // dividend
    localparam int DW  = CW + 1;                           // divisor
    localparam int RW  = CW + 2;                           // partial remainder

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]          state_reg,   state_next;
    logic [CW-1:0]       count_reg,   count_next;
    logic [SLW-1:0]      oldest_reg,  oldest_next;
    logic [SW-1:0]       sum_reg,     sum_next;
    logic [SLW-1:0]      slot_reg,    slot_next;
    logic                evict_reg,   evict_next;
    logic [SAMPLE_W-1:0] sample_reg,  sample_next;
    logic [SAMPLE_W-1:0] ev_val_reg,  ev_val_next;
    logic [DW-1:0]       den_reg,     den_next;
    logic [RW-1:0]       rem_reg,     rem_next;
    logic [SAMPLE_W-1:0] quo_reg,     quo_next;
    logic [STEP_W-1:0]   step_reg,    step_next;
    logic                m_valid_reg, m_valid_next;
    wfa_result_t         out_reg,     out_next;

    logic                accept;
    logic                full;
    logic [AW-1:0]       fill_pos;
    logic [AW-1:0]       adv_pos;
    logic [SAMPLE_W-1:0] ram_rd_data;
    logic [NW-1:0]       dividend;
    logic [RW-1:0]       trial;
    logic                trial_ge;
    logic                out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CW'(WINDOW));
    assign out_free = !m_valid_reg || m_tready;

    // slot positions, wrapping at WINDOW
    assign fill_pos = AW'(oldest_reg) + AW'(count_reg);
    assign adv_pos  = AW'(oldest_reg) + AW'(1);

    assign dividend = {sum_reg, 1'b0} + NW'(count_reg);
    assign trial    = {rem_reg[RW-2:0], quo_reg[SAMPLE_W-1]};
    assign trial_ge = (trial >= RW'(den_reg));

    wfa_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_store (
        .clk     (clk),
        .wr_en   (state_reg == S_LOAD),
        .wr_addr (slot_reg),
        .wr_data (sample_reg),
        .rd_en   (accept),
        .rd_addr (oldest_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        oldest_next  = oldest_reg;
        sum_next     = sum_reg;
        slot_next    = slot_reg;
        evict_next   = evict_reg;
        sample_next  = sample_reg;
        ev_val_next  = ev_val_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sample_next = s_tdata[SAMPLE_W-1:0];
                    evict_next  = full;
                    if (full)
                    begin
                        slot_next = oldest_reg;
                    end
                    else if (fill_pos >= AW'(WINDOW))
                    begin
                        slot_next = SLW'(fill_pos - AW'(WINDOW));
                    end
                    else
                    begin
                        slot_next = SLW'(fill_pos);
                    end
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                // oldest value is on the RAM read port now
                if (evict_reg)
                begin
                    ev_val_next = ram_rd_data;
                    sum_next    = sum_reg - SW'(ram_rd_data) + SW'(sample_reg);
                    oldest_next = (adv_pos >= AW'(WINDOW)) ? '0 : SLW'(adv_pos);
                end
                else
                begin
                    ev_val_next = '0;
                    sum_next    = sum_reg + SW'(sample_reg);
                    count_next  = count_reg + CW'(1);
                end
                state_next = S_PREP;
            end
            S_PREP:
            begin
                // top bits of the dividend are below the divisor: quotient fits
                den_next   = {count_reg, 1'b0};
                rem_next   = RW'(dividend[NW-1:SAMPLE_W]);
                quo_next   = dividend[SAMPLE_W-1:0];
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next  = trial_ge ? (trial - RW'(den_reg)) : trial;
                quo_next  = {quo_reg[SAMPLE_W-2:0], trial_ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SAMPLE_W - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next.ev_flag  = evict_reg;
                    out_next.ev_value = ev_val_reg;
                    out_next.mean     = quo_reg;
                    out_next.count    = COUNT_OUT_W'(count_reg);
                    m_valid_next      = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            oldest_reg  <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            oldest_reg  <= oldest_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        evict_reg  <= evict_next;
        sample_reg <= sample_next;
        ev_val_reg <= ev_val_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        step_reg   <= step_next;
        out_reg    <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.ev_flag;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_reg.count, out_reg.mean, out_reg.ev_value};

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(WINDOW))
        else $error("fill count beyond window");

    a_oldest_bound: assert property (@(posedge clk) disable iff (!rst_n)
        oldest_reg < SLW'(WINDOW) || WINDOW == (1 << SLW))
        else $error("oldest slot out of range");

    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_LOAD)
        else $error("accepted word did not start a RAM read cycle");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |-> rem_reg < RW'(den_reg))
        else $error("divider remainder not below divisor");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PREP && evict_reg |-> count_reg == CW'(WINDOW))
        else $error("eviction with window not full");

endmodule

`default_nettype wire

// ----- bench/wfa_window_monitor.sv -----
// ----------------------------------------------------------------------------
// wfa_window_monitor - result predictor and comparator for the windowed mean
// Watches both stream ports, keeps its own copy of the window, sum and count,
// predicts one result word per accepted sample and checks each output word,
// field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module wfa_window_monitor
    import wfa_pkg::*;
#(
    parameter int WINDOW = 5
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                   m_tuser,
    output int                          mismatch_count,
    output int                          words_outstanding,
    output int                          words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W   = SAMPLE_W + COUNT_W;
    localparam int REPORT_LIMIT = 10;

    logic [SAMPLE_W-1:0] window_vals [WINDOW];
    logic [COUNT_W-1:0]  oldest_idx;
    logic [COUNT_W-1:0]  held_n;
    logic [SUM_W-1:0]    window_sum;

    wfa_result_t expected_words[$];
    int          fails;
    int          checked;

    // Append one sample to the window copy and return the word it must produce.
    function automatic wfa_result_t predict_window_mean(input logic [SAMPLE_W-1:0] sample);
        wfa_result_t     r;
        int              slot;
        logic [SUM_W:0]  numer;
        logic [COUNT_W:0] denom;
        r = '0;
        if (held_n == WINDOW) begin
            // full: drop the oldest, reuse its slot
            r.ev_flag  = 1'b1;
            r.ev_value = window_vals[oldest_idx];
            window_vals[oldest_idx] = sample;
            window_sum = window_sum - r.ev_value + sample;
            oldest_idx = (oldest_idx == WINDOW - 1) ? '0 : oldest_idx + 1'b1;
        end
        else begin
            slot = oldest_idx + held_n;
            if (slot >= WINDOW)
                slot = slot - WINDOW;
            window_vals[slot] = sample;
            window_sum = window_sum + sample;
            held_n     = held_n + 1'b1;
        end
        // round half up: (2*sum + n) / (2*n)
        numer  = {window_sum, 1'b0} + held_n;
        denom  = {held_n, 1'b0};
        r.mean  = SAMPLE_W'(numer / denom);
        r.count = held_n[COUNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic void note_field(input string field, input logic [SAMPLE_W-1:0] want,
                                       input logic [SAMPLE_W-1:0] got);
        if (fails < REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d got %0d", $realtime, field, want, got);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        wfa_result_t want;
        bit          bad;
        if (!rst_n) begin
            foreach (window_vals[i])
                window_vals[i] = '0;
            oldest_idx = '0;
            held_n     = '0;
            window_sum = '0;
            expected_words.delete();
            fails   = 0;
            checked = 0;
            mismatch_count    <= 0;
            words_outstanding <= 0;
            words_checked     <= 0;
        end
        else begin
            // output side first: a word leaving now cannot belong to a sample taken now
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    if (fails < REPORT_LIMIT)
                        $display("%0t: unexpected output word %h, tuser %b",
                                 $realtime, m_tdata, m_tuser);
                    fails++;
                end
                else begin
                    want = expected_words.pop_front();
                    bad  = 1'b0;
                    if (m_tuser !== want.ev_flag) begin
                        note_field("evicted_valid", want.ev_flag, m_tuser);
                        bad = 1'b1;
                    end
                    if (m_tdata[SAMPLE_W-1:0] !== want.ev_value) begin
                        note_field("evicted_value", want.ev_value, m_tdata[SAMPLE_W-1:0]);
                        bad = 1'b1;
                    end
                    if (m_tdata[2*SAMPLE_W-1:SAMPLE_W] !== want.mean) begin
                        note_field("window_mean", want.mean, m_tdata[2*SAMPLE_W-1:SAMPLE_W]);
                        bad = 1'b1;
                    end
                    if (m_tdata[2*SAMPLE_W+COUNT_OUT_W-1:2*SAMPLE_W] !== want.count) begin
                        note_field("held_count", want.count,
                                   m_tdata[2*SAMPLE_W+COUNT_OUT_W-1:2*SAMPLE_W]);
                        bad = 1'b1;
                    end
                    if (bad)
                        fails++;
                    checked++;
                end
            end
            if (s_tvalid && s_tready)
                expected_words.push_back(predict_window_mean(s_tdata[SAMPLE_W-1:0]));
            mismatch_count    <= fails;
            words_outstanding <= expected_words.size();
            words_checked     <= checked;
        end
    end

endmodule

// ----- bench/tb_windowed_fifo_average_top.sv -----
// ----------------------------------------------------------------------------
// tb_windowed_fifo_average_top - stimulus and verdict for the windowed mean
// Drives samples into the block under several handshake mixes, including a
// long output hold-off, and leaves prediction and comparison to the monitor.
// ----------------------------------------------------------------------------
module tb_windowed_fifo_average_top;
    import wfa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  WIN_DEPTH       = 5;
    localparam time CLK_PERIOD      = 10ns;
    localparam int  RESET_CYCLES    = 4;
    localparam int  SAMPLES_PER_MIX = 195;
    // longest output hold-off; the block can only park two samples meanwhile
    localparam int  HOLD_OFF_CYCLES = 300;
    // no legitimate quiet spell comes near this: hold-off plus one sample's
    // processing plus the odd long random gap
    localparam int  QUIET_LIMIT     = 3000;
    // allow a couple of words of slack after the last drain
    localparam int  SETTLE_CYCLES   = 40;

    // Fill phase first: the rounding halves only arise while the window
    // holds two or four values, then extremes and a full wrap of evictions.
    localparam logic [SAMPLE_W-1:0] DIRECTED [22] = '{
        16'd0, 16'd1, 16'd1, 16'd0,                 // means 0, 1 (half up), 1, 1 (half up)
        16'd65535,                                  // window full for the first time
        16'd65535, 16'd65535, 16'd65535, 16'd65535, // evicts the fill values
        16'd65535,                                  // all max: largest sum
        16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,     // alternating bit patterns
        16'd0, 16'd0, 16'd0, 16'd0, 16'd0,          // back down to all zero
        16'd1, 16'd2, 16'd65534                     // small remainders
    };

    logic clk = 1'b0;
    logic rst_n;

    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;     // [15:0] sample_value
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;     // [15:0] evicted_value, [31:16] window_mean,
                                         // [34:32] held_count, pad
    logic                   m_tuser;     // [0] evicted_valid

    int mismatch_count;
    int words_outstanding;
    int words_checked;
    int samples_sent;

    // idling knobs, percent of cycles
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off_request;

    int quiet_cycles;

    always #(CLK_PERIOD / 2) clk = ~clk;

    windowed_fifo_average_top #(
        .WINDOW (WIN_DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    wfa_window_monitor #(
        .WINDOW (WIN_DEPTH)
    ) monitor (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser),
        .mismatch_count    (mismatch_count),
        .words_outstanding (words_outstanding),
        .words_checked     (words_checked)
    );

    // Offer one sample: optional idle gap, then hold tvalid until the word
    // is taken. Returns on the falling edge after acceptance, tvalid still
    // high, so back-to-back words never drop tvalid in between.
    task automatic offer_sample(input logic [SAMPLE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        samples_sent++;
        @(negedge clk);
    endtask

    // Sender goes quiet until every predicted word has come out.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (words_outstanding != 0);
        @(negedge clk);
    endtask

    // Weighted towards the corners: zero, full scale and tiny values make
    // the rounding and eviction arithmetic interesting.
    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return SAMPLE_W'($urandom_range(3));
            3:       return SAMPLE_W'(32'hFFFF - $urandom_range(3));
            default: return SAMPLE_W'($urandom_range(65535));
        endcase
    endfunction

    // Receiver: random stalls, or a long hold-off on request. The hold-off
    // is timed here so that the sender keeps pushing into a full block.
    initial
    begin : receiver
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_off_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
                hold_off_request = 1'b0;
            end
            else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: consecutive cycles with no word moving on either port.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Timeout: no word moved for %0d cycles, %0d words still due",
                 QUIET_LIMIT, words_outstanding);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_off_request = 1'b0;
        samples_sent     = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words, full rate both sides
        foreach (DIRECTED[i])
            offer_sample(DIRECTED[i]);
        wait_for_drain();

        // random words under each handshake mix
        for (int mix = 0; mix < 4; mix++) begin
            case (mix)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            // first mix opens with a long output hold-off while samples keep coming
            if (mix == 0)
                hold_off_request = 1'b1;
            repeat (SAMPLES_PER_MIX)
                offer_sample(random_sample());
            wait_for_drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d samples: window fill, eviction wrap, rounding halves,",
                 samples_sent);
        $display("extremes, four handshake mixes and a long output hold-off; %0d words checked",
                 words_checked);
        if (mismatch_count == 0 && words_outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
